@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file ptt_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PTT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PTT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/ptt_pkg.sv @@
// Types and constants of the periodic timer table.
package ptt_pkg;

	localparam int TIMER_SLOTS = 8;
	localparam int TASK_COUNT  = 16;
	localparam int IDX_W       = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
	localparam int TASK_W      = 4;
	localparam int TIME_W      = 16;
	localparam logic [TIME_W-1:0] FOREVER_COUNT = 16'hffff;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_DELETE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_FIRED  = 2'd1,
		KIND_NONE   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [TASK_W-1:0] task_id;
		logic [TIME_W-1:0] remaining;
		logic [TIME_W-1:0] interval;
		logic [TIME_W-1:0] last_fire;
	} entry_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} mem_req_t;

	typedef struct packed {
		kind_t             kind;
		logic              ok;
		logic [TASK_W-1:0] task_id;
		logic              last;
	} result_t;

endpackage

@@ hw/rtl/periodic_timer_table.sv @@
// Top level of the periodic timer table.
//
// Input channel s_*: one item per command. s_tuser carries the operation
// (create, delete by task, delete all, tick); s_tdata carries task id, count,
// period, start time and current time. Output channel m_*: result items;
// m_tuser is the kind (status, fired, nothing fired), m_tdata holds ok and
// the fired task id, m_tlast marks the final result of a command.
// Create and delete all give their status result without a walk. Delete and
// tick walk the timer memory once, one entry per cycle through its single
// registered read port unless a stalled output holds the walk; the table holds at
// most 8 timers. A tick gives one fired item per firing timer, or
// one nothing-fired item. A new command is taken once the previous one has
// handed its last result to the output register, even if that result still
// waits there. When m_tready stays low the walk holds on the next fired timer.
// Reset empties the table; memory contents are not cleared and are never
// read beyond the live entry count.
module periodic_timer_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // task_id, count, period, start_time, current_time
	input  logic [1:0]  s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // ok, fired_task
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast
);

	ptt_pkg::mem_req_t mem_req;
	ptt_pkg::entry_t   rd_data;
	logic              emit_valid;
	logic              emit_ready;
	ptt_pkg::result_t  emit;
	ptt_pkg::result_t  out_data;

	ptt_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	ptt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.op           (ptt_pkg::op_t'(s_tuser)),
		.task_id      (s_tdata[3:0]),
		.count        (s_tdata[19:4]),
		.period       (s_tdata[35:20]),
		.start_time   (s_tdata[51:36]),
		.current_time (s_tdata[67:52]),
		.mem_req      (mem_req),
		.rd_data      (rd_data),
		.emit_valid   (emit_valid),
		.emit         (emit),
		.emit_ready   (emit_ready)
	);

	ptt_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.emit_valid (emit_valid),
		.emit       (emit),
		.emit_ready (emit_ready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (out_data)
	);

	assign m_tdata = {3'b000, out_data.task_id, out_data.ok};
	assign m_tuser = out_data.kind;
	assign m_tlast = out_data.last;

endmodule

@@ hw/rtl/ptt_mem.sv @@
// Timer entry memory: one write port, one registered read port.
module ptt_mem (
	input  logic              clk,
	input  ptt_pkg::mem_req_t req,
	output ptt_pkg::entry_t   rd_data
);

	ptt_pkg::entry_t mem_q [ptt_pkg::TIMER_SLOTS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem_q[req.rd_addr];
		end
	end

endmodule

@@ hw/rtl/ptt_ctrl.sv @@
// Command sequencer and compacting table walk for create, delete, clear and tick.
module ptt_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ptt_pkg::op_t                  op,
	input  logic [ptt_pkg::TASK_W-1:0]    task_id,
	input  logic [ptt_pkg::TIME_W-1:0]    count,
	input  logic [ptt_pkg::TIME_W-1:0]    period,
	input  logic [ptt_pkg::TIME_W-1:0]    start_time,
	input  logic [ptt_pkg::TIME_W-1:0]    current_time,
	output ptt_pkg::mem_req_t             mem_req,
	input  ptt_pkg::entry_t               rd_data,
	output logic                          emit_valid,
	output ptt_pkg::result_t              emit,
	input  logic                          emit_ready
);

	ptt_pkg::state_t                state_q, state_d;
	ptt_pkg::op_t                   op_q;
	logic [ptt_pkg::CNT_W-1:0]      total_q;
	logic [ptt_pkg::CNT_W-1:0]      rd_idx_q;
	logic [ptt_pkg::CNT_W-1:0]      wr_idx_q;
	logic                           vld_s1;
	logic                           found_q;
	logic                           pend_v_q;
	logic                           ok_q;
	logic [ptt_pkg::TASK_W-1:0]     tid_q;
	logic [ptt_pkg::TASK_W-1:0]     pend_task_q;
	logic [ptt_pkg::TIME_W-1:0]     cur_q;

	logic                           create_ok;
	logic [ptt_pkg::TIME_W-1:0]     elapsed;
	logic                           fire;
	logic                           forever_cnt;
	logic                           is_tick;
	logic                           drop;
	ptt_pkg::entry_t                upd;
	logic                           need_emit;
	logic                           advance;
	logic                           more;
	logic                           walk_end;

	assign create_ok = (count != '0)
		&& (total_q < ptt_pkg::CNT_W'(ptt_pkg::TIMER_SLOTS))
		&& (int'(task_id) < ptt_pkg::TASK_COUNT);

	always_comb begin
		elapsed     = cur_q - rd_data.last_fire;
		fire        = elapsed >= rd_data.interval;
		forever_cnt = rd_data.remaining == ptt_pkg::FOREVER_COUNT;
		is_tick     = op_q == ptt_pkg::OP_TICK;
		upd         = rd_data;
		drop        = 1'b0;
		if (is_tick) begin
			if (fire) begin
				upd.last_fire = cur_q;
				if (!forever_cnt) begin
					upd.remaining = rd_data.remaining - 16'd1;
					drop = rd_data.remaining == 16'd1;
				end
			end
		end else begin
			drop = (rd_data.task_id == tid_q) && !found_q;
		end
		need_emit = vld_s1 && is_tick && fire && pend_v_q;
		advance   = !(need_emit && !emit_ready);
		more      = rd_idx_q < total_q;
		walk_end  = !vld_s1 && !more;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ptt_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (op == ptt_pkg::OP_CREATE || op == ptt_pkg::OP_CLEAR) begin
						state_d = ptt_pkg::ST_DONE;
					end else begin
						state_d = ptt_pkg::ST_WALK;
					end
				end
			end
			ptt_pkg::ST_WALK: begin
				if (walk_end) begin
					state_d = ptt_pkg::ST_DONE;
				end
			end
			ptt_pkg::ST_DONE: begin
				if (emit_ready) begin
					state_d = ptt_pkg::ST_IDLE;
				end
			end
			default: state_d = ptt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = state_q == ptt_pkg::ST_IDLE;
		mem_req.rd_en   = 1'b0;
		mem_req.rd_addr = rd_idx_q[ptt_pkg::IDX_W-1:0];
		mem_req.wr_en   = 1'b0;
		mem_req.wr_addr = wr_idx_q[ptt_pkg::IDX_W-1:0];
		mem_req.wr_data = upd;
		emit_valid      = 1'b0;
		emit.kind       = ptt_pkg::KIND_STATUS;
		emit.ok         = 1'b0;
		emit.task_id    = '0;
		emit.last       = 1'b0;
		case (state_q)
			ptt_pkg::ST_IDLE: begin
				if (in_valid && op == ptt_pkg::OP_CREATE && create_ok) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = total_q[ptt_pkg::IDX_W-1:0];
					mem_req.wr_data = {task_id, count, period, start_time};
				end
			end
			ptt_pkg::ST_WALK: begin
				mem_req.rd_en = advance && more;
				mem_req.wr_en = vld_s1 && advance && !drop;
				emit_valid    = need_emit;
				emit.kind     = ptt_pkg::KIND_FIRED;
				emit.task_id  = pend_task_q;
			end
			ptt_pkg::ST_DONE: begin
				emit_valid = 1'b1;
				emit.last  = 1'b1;
				if (op_q == ptt_pkg::OP_TICK) begin
					if (pend_v_q) begin
						emit.kind    = ptt_pkg::KIND_FIRED;
						emit.task_id = pend_task_q;
					end else begin
						emit.kind = ptt_pkg::KIND_NONE;
					end
				end else begin
					emit.ok = ok_q;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ptt_pkg::ST_IDLE;
			op_q     <= ptt_pkg::OP_CREATE;
			total_q  <= '0;
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
			pend_v_q <= 1'b0;
			ok_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ptt_pkg::ST_IDLE: begin
					if (in_valid) begin
						op_q     <= op;
						rd_idx_q <= '0;
						wr_idx_q <= '0;
						vld_s1   <= 1'b0;
						found_q  <= 1'b0;
						pend_v_q <= 1'b0;
						ok_q     <= 1'b0;
						case (op)
							ptt_pkg::OP_CREATE: begin
								ok_q <= create_ok;
								if (create_ok) begin
									total_q <= total_q + 1'b1;
								end
							end
							ptt_pkg::OP_CLEAR: begin
								total_q <= '0;
								ok_q    <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				ptt_pkg::ST_WALK: begin
					if (walk_end) begin
						total_q <= wr_idx_q;
					end else if (advance) begin
						if (vld_s1) begin
							if (!drop) begin
								wr_idx_q <= wr_idx_q + 1'b1;
							end
							if (is_tick && fire) begin
								pend_v_q <= 1'b1;
							end
							if (!is_tick && drop) begin
								found_q <= 1'b1;
								ok_q    <= 1'b1;
							end
						end
						vld_s1 <= more;
						if (more) begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ptt_pkg::ST_IDLE && in_valid) begin
			tid_q <= task_id;
			cur_q <= current_time;
		end
		if (state_q == ptt_pkg::ST_WALK && advance && vld_s1 && is_tick && fire) begin
			pend_task_q <= rd_data.task_id;
		end
	end

endmodule

@@ hw/rtl/ptt_out.sv @@
// Output register for result items.
module ptt_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             emit_valid,
	input  ptt_pkg::result_t emit,
	output logic             emit_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output ptt_pkg::result_t out_data
);

	logic             valid_q;
	ptt_pkg::result_t data_q;

	assign emit_ready = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_data   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit_ready) begin
			valid_q <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ready && emit_valid) begin
			data_q <= emit;
		end
	end

endmodule

@@ hw/rtl/ptt_chk.sv @@
// Port checker for the periodic timer table, bound to the top level.
`include "assert_macros.svh"

module ptt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	`PTT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result item changed")
	`PTT_ASSERT_IMP(a_status_form, m_tvalid && m_tuser == ptt_pkg::KIND_STATUS, m_tlast && m_tdata[4:1] == 4'd0, "status item must be last with no task")
	`PTT_ASSERT_IMP(a_none_form, m_tvalid && m_tuser == ptt_pkg::KIND_NONE, m_tlast && m_tdata[4:0] == 5'd0, "nothing-fired item malformed")
	`PTT_ASSERT_IMP(a_ok_status_only, m_tvalid && m_tuser != ptt_pkg::KIND_STATUS, !m_tdata[0], "ok set outside status item")
	`PTT_ASSERT_NXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "second item taken before first finished")

endmodule

bind periodic_timer_table ptt_chk u_ptt_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

@@ bench/periodic_timer_table_tb.sv @@
// Self-checking testbench for the periodic timer table: directed table, then random traffic.
module periodic_timer_table_tb;

	import ptt_pkg::*;

	localparam int RANDOM_ITEMS = 288;

	typedef struct packed {
		op_t         op;
		logic [3:0]  task_id;
		logic [15:0] count;
		logic [15:0] period;
		logic [15:0] start_time;
		logic [15:0] current_time;
	} command_t;

	typedef struct {
		command_t cmd;
		bit       typed;
		result_t  want;
	} vector_t;

	localparam result_t R_OK    = '{KIND_STATUS, 1'b1, 4'd0, 1'b1};
	localparam result_t R_FAULT = '{KIND_STATUS, 1'b0, 4'd0, 1'b1};
	localparam result_t R_IDLE  = '{KIND_NONE, 1'b0, 4'd0, 1'b1};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	periodic_timer_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [3:0]  tbl_task   [TIMER_SLOTS];
	logic [15:0] tbl_left   [TIMER_SLOTS];
	logic [15:0] tbl_period [TIMER_SLOTS];
	logic [15:0] tbl_stamp  [TIMER_SLOTS];
	int          tbl_used = 0;
	logic [15:0] sim_clock = '0;

	result_t expected_results[$];
	vector_t plan[$];
	int      failures = 0;
	int      items_sent = 0;
	int      results_seen = 0;
	int      fires_seen = 0;
	int      faults_seen = 0;
	int      ready_left = 0;
	int      stall_left = 0;

	function automatic void drop_slot(int pos);
		for (int i = pos; i + 1 < tbl_used; i++) begin
			tbl_task[i]   = tbl_task[i + 1];
			tbl_left[i]   = tbl_left[i + 1];
			tbl_period[i] = tbl_period[i + 1];
			tbl_stamp[i]  = tbl_stamp[i + 1];
		end
		if (tbl_used > 0)
			tbl_used--;
	endfunction

	function automatic void step_timers(input command_t c, output result_t res[$]);
		int          i;
		logic [15:0] elapsed;
		bit          done;
		bit          expired;
		res = {};
		done = 1'b0;
		case (c.op)
			OP_CREATE: begin
				if (c.count != 0 && tbl_used < TIMER_SLOTS && c.task_id < TASK_COUNT) begin
					tbl_task[tbl_used]   = c.task_id;
					tbl_left[tbl_used]   = c.count;
					tbl_period[tbl_used] = c.period;
					tbl_stamp[tbl_used]  = c.start_time;
					tbl_used++;
					done = 1'b1;
				end
			end
			OP_DELETE: begin
				i = 0;
				while (!done && i < tbl_used) begin
					if (tbl_task[i] == c.task_id) begin
						drop_slot(i);
						done = 1'b1;
					end else begin
						i++;
					end
				end
			end
			OP_CLEAR: begin
				tbl_used = 0;
				done = 1'b1;
			end
			default: begin
				i = 0;
				while (i < tbl_used) begin
					elapsed = c.current_time - tbl_stamp[i];
					expired = 1'b0;
					if (elapsed >= tbl_period[i]) begin
						res.push_back('{KIND_FIRED, 1'b0, tbl_task[i], 1'b0});
						tbl_stamp[i] = c.current_time;
						if (tbl_left[i] != FOREVER_COUNT) begin
							tbl_left[i]--;
							expired = (tbl_left[i] == 0);
						end
					end
					if (expired)
						drop_slot(i);
					else
						i++;
				end
				if (res.size() == 0)
					res.push_back(R_IDLE);
				else
					res[res.size() - 1].last = 1'b1;
			end
		endcase
		if (c.op != OP_TICK)
			res.push_back('{KIND_STATUS, done, 4'd0, 1'b1});
	endfunction

	function automatic command_t random_command();
		command_t c;
		int       pick;
		c.op = OP_CLEAR;
		c.task_id = 4'($urandom_range(0, 15));
		c.count = 16'($urandom);
		c.period = 16'($urandom);
		c.start_time = 16'($urandom);
		c.current_time = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 36) begin
			c.op = OP_CREATE;
			case ($urandom_range(0, 5))
				0: c.count = FOREVER_COUNT;
				1: c.count = 16'd0;
				2: c.count = 16'($urandom);
				default: c.count = 16'($urandom_range(1, 4));
			endcase
			if ($urandom_range(0, 7) != 0)
				c.period = 16'($urandom_range(0, 24));
			if ($urandom_range(0, 7) != 0)
				c.start_time = sim_clock - 16'($urandom_range(0, 8));
		end else if (pick < 78) begin
			c.op = OP_TICK;
			if ($urandom_range(0, 15) != 0)
				sim_clock = sim_clock + 16'($urandom_range(0, 12));
			else
				sim_clock = 16'($urandom);
			c.current_time = sim_clock;
		end else if (pick < 96) begin
			c.op = OP_DELETE;
			if (tbl_used > 0 && $urandom_range(0, 3) != 0)
				c.task_id = tbl_task[$urandom_range(0, tbl_used - 1)];
		end
		return c;
	endfunction

	task automatic add_row(input op_t op, input logic [3:0] task_id, input logic [15:0] count,
			input logic [15:0] period, input logic [15:0] start_time,
			input logic [15:0] current_time, input bit typed, input result_t want);
		vector_t v;
		v.cmd = '{op, task_id, count, period, start_time, current_time};
		v.typed = typed;
		v.want = want;
		plan.push_back(v);
	endtask

	// call right after a rising edge; returns right after the edge that took the item
	task automatic drive_item(input command_t c, input bit typed, input result_t want);
		result_t res[$];
		s_tvalid <= 1'b1;
		s_tuser <= c.op;
		s_tdata <= {4'd0, c.current_time, c.start_time, c.period, c.count, c.task_id};
		do @(posedge clk); while (!s_tready);
		step_timers(c, res);
		items_sent++;
		if (typed)
			expected_results.push_back(want);
		else
			foreach (res[k])
				expected_results.push_back(res[k]);
	endtask

	always @(posedge clk) begin : monitor
		result_t got;
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.kind = kind_t'(m_tuser);
				got.ok = m_tdata[0];
				got.task_id = m_tdata[4:1];
				got.last = m_tlast;
				results_seen++;
				if (got.kind == KIND_FIRED)
					fires_seen++;
				if (got.kind == KIND_STATUS && !got.ok)
					faults_seen++;
				if (expected_results.size() == 0) begin
					$error("unexpected result: kind %0d ok %0d fired_task %0d last %0d",
						got.kind, got.ok, got.task_id, got.last);
					failures++;
				end else begin
					want = expected_results.pop_front();
					if (got.kind != want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, got.kind);
						failures++;
					end
					if (got.ok != want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, got.ok);
						failures++;
					end
					if (got.task_id != want.task_id) begin
						$error("fired_task: expected %0d, got %0d", want.task_id, got.task_id);
						failures++;
					end
					if (got.last != want.last) begin
						$error("last: expected %0d, got %0d", want.last, got.last);
						failures++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (ready_left > 0) begin
				ready_left--;
				m_tready <= 1'b1;
			end else begin
				ready_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
				stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				m_tready <= (stall_left == 0);
			end
		end
	end

	initial begin
		int       idx;
		int       burst_left;
		int       gap;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(OP_TICK,   4'd0,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, R_IDLE);
		add_row(OP_DELETE, 4'd3,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, R_FAULT);
		add_row(OP_CLEAR,  4'd0,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, R_OK);
		add_row(OP_CREATE, 4'd6,  16'h0000, 16'h0005, 16'h0000, 16'h0000, 1'b1, R_FAULT);
		add_row(OP_CREATE, 4'd0,  16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b1, R_OK);
		add_row(OP_CREATE, 4'd15, 16'hffff, 16'hffff, 16'hffff, 16'h0000, 1'b1, R_OK);
		add_row(OP_CREATE, 4'd5,  16'h0002, 16'h000a, 16'h0000, 16'h0000, 1'b1, R_OK);
		add_row(OP_CREATE, 4'd5,  16'h0003, 16'h0000, 16'hfff0, 16'h0000, 1'b1, R_OK);
		add_row(OP_CREATE, 4'd9,  16'hfffe, 16'h8000, 16'h1234, 16'h0000, 1'b1, R_OK);
		add_row(OP_CREATE, 4'd10, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 1'b1, R_OK);
		add_row(OP_CREATE, 4'd12, 16'h0005, 16'h0064, 16'hfffa, 16'h0000, 1'b1, R_OK);
		add_row(OP_CREATE, 4'd3,  16'h0001, 16'hffff, 16'h0000, 16'h0000, 1'b1, R_OK);
		add_row(OP_CREATE, 4'd7,  16'h0001, 16'h0001, 16'h0000, 16'h0000, 1'b1, R_FAULT);
		add_row(OP_TICK,   4'd0,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, R_OK);
		add_row(OP_TICK,   4'd0,  16'h0000, 16'h0000, 16'h0000, 16'hfffe, 1'b0, R_OK);
		add_row(OP_TICK,   4'd0,  16'h0000, 16'h0000, 16'h0000, 16'hffff, 1'b0, R_OK);
		add_row(OP_DELETE, 4'd5,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, R_OK);
		add_row(OP_DELETE, 4'd15, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, R_OK);
		add_row(OP_DELETE, 4'd8,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, R_FAULT);
		add_row(OP_TICK,   4'd0,  16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b0, R_OK);
		add_row(OP_TICK,   4'd0,  16'h0000, 16'h0000, 16'h0000, 16'h8005, 1'b0, R_OK);
		add_row(OP_CLEAR,  4'd0,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, R_OK);
		add_row(OP_TICK,   4'd0,  16'h0000, 16'h0000, 16'h0000, 16'h1234, 1'b1, R_IDLE);

		for (idx = 0; idx < plan.size(); idx++)
			drive_item(plan[idx].cmd, plan[idx].typed, plan[idx].want);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
		sim_clock = 16'h1234;

		burst_left = 0;
		for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
			if (idx == RANDOM_ITEMS / 2) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (expected_results.size() != 0);
				burst_left = $urandom_range(1, 8);
			end else if (burst_left <= 0) begin
				burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 8);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			drive_item(random_command(), 1'b0, R_OK);
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
		repeat (40) @(posedge clk);

		$display("Covered %0d commands and %0d results: %0d timer fires, %0d faulted commands.",
			items_sent, results_seen, fires_seen, faults_seen);
		if (failures == 0)
			$display("PASS periodic_timer_table");
		else
			$display("FAIL periodic_timer_table");
		$finish;
	end

	initial begin
		#4000000;
		$display("FAIL periodic_timer_table");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_mem.sv
hw/rtl/ptt_ctrl.sv
hw/rtl/ptt_out.sv
hw/rtl/periodic_timer_table.sv
hw/rtl/ptt_chk.sv
bench/periodic_timer_table_tb.sv
